@@ rtl/core/fmo_pkg.sv @@
// ----------------------------------------------------------------------------
// fmo_pkg
// Shared types, register map and constant functions of the two-operator
// FM oscillator.
// ----------------------------------------------------------------------------
package fmo_pkg;

    typedef longint unsigned u64_t;

    localparam int PADDR_BITS   = 4;
    localparam int REG_IDX_BITS = 2;
    localparam int STEP_BITS    = 32;
    localparam int RATIO_BITS   = 16;
    localparam int DEV_BITS     = 32;

    localparam logic [STEP_BITS-1:0]  CARRIER_STEP_RST = 32'd4280492;
    localparam logic [RATIO_BITS-1:0] RATIO_RST        = 16'd512;
    localparam logic [DEV_BITS-1:0]   DEVIATION_RST    = 32'd0;

    // modulator increment that belongs to the reset register values
    localparam u64_t INC_MOD_RST_WIDE = (u64_t'(CARRIER_STEP_RST) * u64_t'(RATIO_RST)) >> 8;
    localparam logic [STEP_BITS-1:0] INC_MOD_RST = INC_MOD_RST_WIDE[STEP_BITS-1:0];

    // pi/2 in Q30
    localparam u64_t HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CARRIER_STEP = 2'd0,
        REG_RATIO        = 2'd1,
        REG_DEVIATION    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] carrier_step;
        logic [DEV_BITS-1:0]  deviation;
    } fmo_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fmo_q_stat_t;

    // Unsigned 64-bit quotient by restoring long division. Elaboration time
    // only.
    function automatic u64_t fmo_udiv(input u64_t num, input u64_t den);
        logic [63:0] n;
        logic [63:0] quo;
        logic [63:0] rem;
        n   = num;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave table entry j: Taylor series through x^17 in Q30,
    // scaled to the peak and rounded half up. Elaboration time only.
    function automatic longint fmo_sine_entry(input int j, input int addr_bits,
                                              input int frac_bits);
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint sum;
        longint e;
        longint peak;
        x    = (HALF_PI_Q30 * u64_t'(j)) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        peak = (longint'(1) << frac_bits) - 1;
        for (int k = 1; k <= 8; k++) begin
            term = fmo_udiv((term * x2) >> 30, u64_t'((2 * k) * (2 * k + 1)));
            if ((k & 1) != 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        e = (sum * peak + (longint'(1) << 29)) >>> 30;
        if (e > peak)
            e = peak;
        return e;
    endfunction

    // Turn*2^32 increment to phase units, left aligned in 48 bits then
    // shifted down to pb bits; caller keeps the low pb bits.
    function automatic logic [47:0] fmo_to_units(input logic [31:0] v, input int pb);
        return {v, 16'h0000} >> (48 - pb);
    endfunction

endpackage

@@ rtl/core/fmo_if.sv @@
// ----------------------------------------------------------------------------
// fmo_if
// Valid/ready channels of the FM oscillator: tick requests in, samples out.
// ----------------------------------------------------------------------------
interface fmo_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface fmo_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/core/fmo_sine_rom.sv @@
// ----------------------------------------------------------------------------
// fmo_sine_rom
// Quarter-wave sine table, 2^ADDR_BITS+1 entries, registered read.
// ----------------------------------------------------------------------------
module fmo_sine_rom
    import fmo_pkg::*;
#(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 15
)(
    input  logic                 clk,
    input  logic                 en,
    input  logic [ADDR_BITS:0]   addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int ROM_DEPTH = (1 << ADDR_BITS) + 1;

    typedef logic [DATA_BITS-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int j = 0; j < ROM_DEPTH; j++)
            r[j] = DATA_BITS'(fmo_sine_entry(j, ADDR_BITS, DATA_BITS));
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [DATA_BITS-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= SINE_ROM[addr];
    end

    assign rd_data = data_reg;

endmodule

@@ rtl/core/fmo_queue.sv @@
// ----------------------------------------------------------------------------
// fmo_queue
// Small register FIFO between the tick front end and the sample pipeline.
// ----------------------------------------------------------------------------
module fmo_queue
    import fmo_pkg::*;
#(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fmo_q_stat_t      stat
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

endmodule

@@ rtl/core/fmo_front.sv @@
// ----------------------------------------------------------------------------
// fmo_front
// Register file, tick intake and modulator phase accumulator. Each accepted
// tick leaves the modulator phase it samples, plus its restart flag, in the
// queue.
// ----------------------------------------------------------------------------
module fmo_front
    import fmo_pkg::*;
#(
    parameter int PHASE_BITS = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    fmo_tick_if.sink              tick,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    input  fmo_q_stat_t           q_stat,
    output logic                  push,
    output logic [PHASE_BITS:0]   push_data,
    output fmo_cfg_t              cfg
);

    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [RATIO_BITS-1:0] ratio_reg, ratio_next;
    logic [DEV_BITS-1:0]   dev_reg, dev_next;
    logic [STEP_BITS-1:0]  inc_mod_reg, inc_mod_next;
    logic [PHASE_BITS-1:0] mod_phase_reg, mod_phase_next;

    logic                  wr_en;
    reg_idx_t              reg_sel;
    logic [47:0]           mul_full;
    logic [47:0]           units_wide;
    logic [PHASE_BITS-1:0] base_phase;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[PADDR_BITS-1:2]);

    always_comb
    begin
        step_next  = step_reg;
        ratio_next = ratio_reg;
        dev_next   = dev_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_CARRIER_STEP: step_next  = pwdata;
                REG_RATIO:        ratio_next = pwdata[RATIO_BITS-1:0];
                REG_DEVIATION:    dev_next   = pwdata;
                default:          ;
            endcase
        end
        // track step*ratio so the increment is ready with the register
        mul_full     = 48'(step_next) * 48'(ratio_next);
        inc_mod_next = mul_full[39:8];
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CARRIER_STEP: prdata = step_reg;
            REG_RATIO:        prdata = {16'h0000, ratio_reg};
            REG_DEVIATION:    prdata = dev_reg;
            default:          prdata = 32'h0000_0000;
        endcase
    end

    assign tick.ready = !q_stat.full;
    assign push       = tick.valid && !q_stat.full;

    always_comb
    begin
        base_phase     = tick.restart ? '0 : mod_phase_reg;
        units_wide     = fmo_to_units(inc_mod_reg, PHASE_BITS);
        mod_phase_next = mod_phase_reg;
        if (push)
            mod_phase_next = base_phase + units_wide[PHASE_BITS-1:0];
    end

    assign push_data = {tick.restart, base_phase};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= CARRIER_STEP_RST;
            ratio_reg     <= RATIO_RST;
            dev_reg       <= DEVIATION_RST;
            inc_mod_reg   <= INC_MOD_RST;
            mod_phase_reg <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            ratio_reg     <= ratio_next;
            dev_reg       <= dev_next;
            inc_mod_reg   <= inc_mod_next;
            mod_phase_reg <= mod_phase_next;
        end
    end

    assign cfg.carrier_step = step_reg;
    assign cfg.deviation    = dev_reg;

endmodule

@@ rtl/core/fmo_back.sv @@
// ----------------------------------------------------------------------------
// fmo_back
// Sample pipeline: modulator sine, deviation multiply, carrier increment,
// carrier phase accumulator, carrier sine, output register. The whole
// pipeline advances together whenever the output register can move.
// ----------------------------------------------------------------------------
module fmo_back
    import fmo_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    input  fmo_cfg_t            cfg,
    input  fmo_q_stat_t         q_stat,
    input  logic [PHASE_BITS:0] pop_data,
    output logic                pop,
    fmo_sample_if.source        result
);

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int PROD_BITS = SAMPLE_BITS + DEV_BITS;
    localparam int TOP_LSB   = PHASE_BITS - SINE_ADDR_BITS - 2;
    localparam logic [SINE_ADDR_BITS:0] TAB_N = {1'b1, {SINE_ADDR_BITS{1'b0}}};

    // top phase bits give quadrant and index; odd quadrants mirror the table
    function automatic logic [SINE_ADDR_BITS:0] rom_addr(input logic [PHASE_BITS-1:0] ph);
        logic [SINE_ADDR_BITS+1:0] top;
        logic [SINE_ADDR_BITS:0]   idx;
        top = ph[PHASE_BITS-1:TOP_LSB];
        idx = {1'b0, top[SINE_ADDR_BITS-1:0]};
        return top[SINE_ADDR_BITS] ? (TAB_N - idx) : idx;
    endfunction

    logic en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rst1_reg, rst2_reg, rst3_reg;
    logic neg1_reg, neg5_reg;

    logic                         head_restart;
    logic [PHASE_BITS-1:0]        head_phase;
    logic [FRAC_BITS-1:0]         rom_mod_data;
    logic [FRAC_BITS-1:0]         rom_car_data;
    logic signed [SAMPLE_BITS-1:0] m_val;
    logic signed [DEV_BITS-1:0]   dev_s;
    logic signed [PROD_BITS-1:0]  prod_reg, prod_next;
    logic signed [PROD_BITS-1:0]  fl_wide;
    logic [STEP_BITS-1:0]         inc_reg, inc_next;
    logic [PHASE_BITS-1:0]        car_reg, car_next;
    logic [PHASE_BITS-1:0]        car_base;
    logic [47:0]                  car_units;
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;

    assign en  = !out_valid_reg || result.ready;
    assign pop = en && !q_stat.empty;

    assign head_restart = pop_data[PHASE_BITS];
    assign head_phase   = pop_data[PHASE_BITS-1:0];

    fmo_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS),
        .DATA_BITS (FRAC_BITS)
    ) u_rom_mod (
        .clk     (clk),
        .en      (en),
        .addr    (rom_addr(head_phase)),
        .rd_data (rom_mod_data)
    );

    fmo_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS),
        .DATA_BITS (FRAC_BITS)
    ) u_rom_car (
        .clk     (clk),
        .en      (en),
        .addr    (rom_addr(car_reg)),
        .rd_data (rom_car_data)
    );

    always_comb
    begin
        dev_s     = signed'(cfg.deviation);
        m_val     = neg1_reg ? -signed'({1'b0, rom_mod_data}) : signed'({1'b0, rom_mod_data});
        prod_next = m_val * dev_s;
        // arithmetic shift floors toward minus infinity
        fl_wide   = prod_reg >>> FRAC_BITS;
        inc_next  = cfg.carrier_step + fl_wide[STEP_BITS-1:0];
        car_base  = rst3_reg ? '0 : car_reg;
        car_units = fmo_to_units(inc_reg, PHASE_BITS);
        car_next  = car_reg;
        if (en && v3_reg)
            car_next = car_base + car_units[PHASE_BITS-1:0];
        sample_next = neg5_reg ? -signed'({1'b0, rom_car_data})
                               : signed'({1'b0, rom_car_data});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            car_reg       <= '0;
        end
        else
        begin
            car_reg <= car_next;
            if (en)
            begin
                v1_reg        <= pop;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                out_valid_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rst1_reg   <= head_restart;
            neg1_reg   <= head_phase[PHASE_BITS-1];
            rst2_reg   <= rst1_reg;
            prod_reg   <= prod_next;
            rst3_reg   <= rst2_reg;
            inc_reg    <= inc_next;
            neg5_reg   <= car_reg[PHASE_BITS-1];
            sample_reg <= sample_next;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.sample = sample_reg;

endmodule

@@ rtl/core/two_operator_fm_oscillator_core.sv @@
// ----------------------------------------------------------------------------
// two_operator_fm_oscillator_core
// Two-operator FM oscillator, one sine sample per tick beat.
// ----------------------------------------------------------------------------
// Channels: tick (sink) carries one request per beat with a restart flag that
// zeroes both phases before that sample; result (source) returns one signed
// sample per tick, in order. Both are valid/ready.
// Registers on the APB port: carrier_step at 0x0, ratio (Q8.8) at 0x4,
// deviation at 0x8. pready is tied high; write only while no tick is in
// flight.
// Throughput: one tick per cycle while result is not held. A sample reaches
// result through the queue, modulator sine, multiply, carrier add, carrier
// phase, carrier sine and output register, in that order.
// The carrier phase accumulator closes its loop through a single register,
// which sets the one-tick-per-cycle rate.
// Reset: registers return to their defaults and both phases clear; the queue
// and pipeline empty.
// Stall: when result is held, the pipeline freezes and ticks keep landing in
// the queue until it fills, then tick.ready drops.
// ----------------------------------------------------------------------------
module two_operator_fm_oscillator_core
    import fmo_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16,
    parameter int QUEUE_DEPTH    = 4
)(
    input  logic                  clk,
    input  logic                  rst_n,
    fmo_tick_if.sink              tick,
    fmo_sample_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                push;
    logic                pop;
    logic [PHASE_BITS:0] push_data;
    logic [PHASE_BITS:0] pop_data;
    fmo_q_stat_t         q_stat;
    fmo_cfg_t            cfg;

    assign pready = 1'b1;

    fmo_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data),
        .cfg       (cfg)
    );

    fmo_queue #(
        .WIDTH (PHASE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    fmo_back #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .result   (result)
    );

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("queue empty after a tick was pushed");

    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !q_stat.full)
        else $error("queue full after a pop");

    a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !pop)
        else $error("queue drained while the output is stalled");

endmodule
